/* rtl/core/scd_pkg.sv */
// Package with the constants, types and helper functions of the command line decoder.
package scd_pkg;

    // Line store size; one entry is kept free so a line holds up to BUFFER_BYTES-1 characters.
    localparam int BUFFER_BYTES = 32;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);

    // Control characters.
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_DEL = 8'h7F;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // Command words, first character in the most significant byte.
    localparam logic [31:0] WORD_READ   = "READ";
    localparam logic [47:0] WORD_STREAM = "STREAM";
    localparam logic [31:0] WORD_STOP   = "STOP";
    localparam logic [31:0] WORD_HELP   = "HELP";

    // Event codes returned with every word.
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_EMPTY      = 3'd1,
        EV_READ       = 3'd2,
        EV_STREAM_ON  = 3'd3,
        EV_STREAM_OFF = 3'd4,
        EV_HELP       = 3'd5,
        EV_UNKNOWN    = 3'd6
    } event_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_OUT
    } state_t;

    // Running match flags, one per command word.
    typedef struct packed {
        logic read;
        logic stream;
        logic stop;
        logic help;
    } match_t;

    // Fold a-z to upper case; every other byte passes unchanged.
    function automatic logic [7:0] fold_upper(logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Character i of a four letter word.
    function automatic logic [7:0] word4_char(logic [31:0] w, logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // Character i of a six letter word.
    function automatic logic [7:0] word6_char(logic [47:0] w, logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = w[47:40];
            3'd1:    r = w[39:32];
            3'd2:    r = w[31:24];
            3'd3:    r = w[23:16];
            3'd4:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/serial_command_line_decoder.sv */
// Top level of the serial command line decoder: line store, compare sequencer and result register.
// Timing: a stored, erased or dropped byte gives its result word in the cycle after acceptance;
// a line end on a four or six character line walks the line store, in ST_FETCH (registered read)
// and then ST_CMP (compare) for each character, before its result word is shown in ST_OUT.
// A new byte is taken only once the result word of the last one has been accepted.
// Reset: aresetn (synchronous, active low) empties the line and clears the streaming flag.
module serial_command_line_decoder
    import scd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [2:0] line_event, [3] stream_enabled, [4] char_dropped
);

    localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_BYTES - 1);
    localparam logic [ADDR_W-1:0] LEN4     = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] LEN6     = ADDR_W'(6);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [2:0]        idx_reg, idx_next;
    logic              stream_reg, stream_next;
    match_t            match_reg, match_next;
    event_t            ev_reg, ev_next;
    logic              drop_reg, drop_next;
    logic [7:0]        rd_data_reg;

    logic [7:0] line_mem [BUFFER_BYTES];

    logic       in_word;
    logic       is_end;
    logic       is_erase;
    logic       store_en;
    logic       cmp_last;
    logic [7:0] folded;
    match_t     match_cmp;

    assign in_word  = s_tvalid && s_tready;
    assign is_end   = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
    assign is_erase = (s_tdata == CHAR_BS) || (s_tdata == CHAR_DEL);
    assign store_en = in_word && !is_end && !is_erase && (fill_reg < FILL_MAX);
    assign cmp_last = (ADDR_W'(idx_reg) + ADDR_W'(1)) == fill_reg;

    // Shared compare unit: fold the fetched character and test it against each word.
    always_comb begin
        folded           = fold_upper(rd_data_reg);
        match_cmp.read   = match_reg.read   && (folded == word4_char(WORD_READ, idx_reg[1:0]));
        match_cmp.stream = match_reg.stream && (folded == word6_char(WORD_STREAM, idx_reg));
        match_cmp.stop   = match_reg.stop   && (folded == word4_char(WORD_STOP, idx_reg[1:0]));
        match_cmp.help   = match_reg.help   && (folded == word4_char(WORD_HELP, idx_reg[1:0]));
    end

    // Line store: written with each kept character, read one entry at a time for compares.
    always_ff @(posedge aclk) begin
        if (store_en) begin
            line_mem[fill_reg] <= s_tdata;
        end
        rd_data_reg <= line_mem[ADDR_W'(idx_reg)];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_word) begin
                    if (is_end && (fill_reg == LEN4 || fill_reg == LEN6)) begin
                        state_next = ST_FETCH;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (cmp_last) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and result selection.
    always_comb begin
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        stream_next = stream_reg;
        match_next  = match_reg;
        ev_next     = ev_reg;
        drop_next   = drop_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_word) begin
                    ev_next   = EV_NONE;
                    drop_next = 1'b0;
                    idx_next  = 3'd0;
                    if (is_end) begin
                        match_next.read   = (fill_reg == LEN4);
                        match_next.stream = (fill_reg == LEN6);
                        match_next.stop   = (fill_reg == LEN4);
                        match_next.help   = (fill_reg == LEN4);
                        if (fill_reg == '0) begin
                            ev_next = EV_EMPTY;
                        end else if (fill_reg != LEN4 && fill_reg != LEN6) begin
                            ev_next   = EV_UNKNOWN;
                            fill_next = '0;
                        end
                    end else if (is_erase) begin
                        if (fill_reg != '0) begin
                            fill_next = fill_reg - ADDR_W'(1);
                        end
                    end else if (fill_reg < FILL_MAX) begin
                        fill_next = fill_reg + ADDR_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
            end
            ST_CMP: begin
                match_next = match_cmp;
                idx_next   = idx_reg + 3'd1;
                if (cmp_last) begin
                    fill_next = '0;
                    if (match_cmp.read) begin
                        ev_next = EV_READ;
                    end else if (match_cmp.stream) begin
                        ev_next     = EV_STREAM_ON;
                        stream_next = 1'b1;
                    end else if (match_cmp.stop) begin
                        ev_next     = EV_STREAM_OFF;
                        stream_next = 1'b0;
                    end else if (match_cmp.help) begin
                        ev_next = EV_HELP;
                    end else begin
                        ev_next = EV_UNKNOWN;
                    end
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            stream_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            stream_reg <= stream_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        match_reg <= match_next;
        ev_reg    <= ev_next;
        drop_reg  <= drop_next;
    end

    // Handshake and result word.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'b000, drop_reg, stream_reg, ev_reg};

`ifndef ASSERT_OFF
    // The block never takes a byte while a result word is pending.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // The line never grows past the last usable entry.
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= FILL_MAX)
        else $error("line fill out of range");

    // A dropped character never comes with a line event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && drop_reg) |-> (ev_reg == EV_NONE))
        else $error("drop flagged with a line event");

    // A stream-on event always reports streaming enabled, stream-off disabled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (ev_reg == EV_STREAM_ON || ev_reg == EV_STREAM_OFF))
        |-> (stream_reg == (ev_reg == EV_STREAM_ON)))
        else $error("stream flag disagrees with event");

    // A line end always leaves the line empty once its result is shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ev_reg != EV_NONE) |-> (fill_reg == '0))
        else $error("line not cleared after line end");
`endif

endmodule

/* tb/serial_command_line_decoder_test.sv */
// Self-checking testbench for the serial command line decoder: directed table, then random lines.
module serial_command_line_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int HOLD_AT        = 300;
    localparam int PAUSE_AT       = 900;
    localparam int QUIET_ITEMS    = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // One result word as the decoder reports it.
    typedef struct packed {
        event_t ev;
        logic   stream;
        logic   dropped;
    } line_result_t;

    // One row of the directed table; fixed rows carry a typed-in result.
    typedef struct packed {
        logic [7:0]   rx;
        logic         fixed;
        line_result_t res;
    } dir_row_t;

    localparam line_result_t PREDICTED = '{EV_NONE, 1'b0, 1'b0};

    dir_row_t directed_rows [28] = '{
        '{8'h0D, 1'b1, '{EV_EMPTY, 1'b0, 1'b0}},
        '{8'h08, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
        '{"s", 1'b0, PREDICTED},
        '{"T", 1'b0, PREDICTED},
        '{"r", 1'b0, PREDICTED},
        '{"e", 1'b0, PREDICTED},
        '{"A", 1'b0, PREDICTED},
        '{"m", 1'b0, PREDICTED},
        '{8'h0A, 1'b1, '{EV_STREAM_ON, 1'b1, 1'b0}},
        '{"h", 1'b0, PREDICTED},
        '{"E", 1'b0, PREDICTED},
        '{"l", 1'b0, PREDICTED},
        '{"p", 1'b0, PREDICTED},
        '{8'h0D, 1'b1, '{EV_HELP, 1'b1, 1'b0}},
        '{"r", 1'b0, PREDICTED},
        '{"e", 1'b0, PREDICTED},
        '{"a", 1'b0, PREDICTED},
        '{"d", 1'b0, PREDICTED},
        '{8'h7F, 1'b1, '{EV_NONE, 1'b1, 1'b0}},
        '{"D", 1'b0, PREDICTED},
        '{8'h0A, 1'b1, '{EV_READ, 1'b1, 1'b0}},
        '{8'h00, 1'b0, PREDICTED},
        '{8'h0D, 1'b1, '{EV_UNKNOWN, 1'b1, 1'b0}},
        '{"S", 1'b0, PREDICTED},
        '{"t", 1'b0, PREDICTED},
        '{"O", 1'b0, PREDICTED},
        '{"p", 1'b0, PREDICTED},
        '{8'h0D, 1'b1, '{EV_STREAM_OFF, 1'b0, 1'b0}}
    };

    // Bytes around the a-z and A-Z ranges that must not be folded.
    logic [7:0] fold_edges [4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [2:0] line_event, [3] stream_enabled, [4] char_dropped

    // Typed-in expectation that travels with the byte on offer.
    logic         row_fixed  = 1'b0;
    line_result_t row_expect = '0;

    // Predicted decoder state.
    logic [7:0] line_chars [BUFFER_BYTES];
    int         line_len  = 0;
    logic       stream_on = 1'b0;

    line_result_t pending_results [$];
    logic [7:0]   rx_plan [$];

    int mismatch_count = 0;
    int bytes_taken    = 0;
    int results_seen   = 0;
    int dropped_seen   = 0;
    int event_seen [7];
    int stall_cycles   = 0;
    bit hold_request   = 1'b0;
    bit hold_done      = 1'b0;
    bit quiet_tail     = 1'b0;

    serial_command_line_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Count a failure and show the first few of them.
    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // Does the stored line equal a command word, a-z folded to upper case?
    function automatic bit line_is(logic [47:0] cmd_word, int cmd_len);
        bit         hit;
        logic [7:0] ch;
        hit = (line_len == cmd_len);
        for (int i = 0; i < cmd_len; i++) begin
            ch = line_chars[i];
            if (ch >= "a" && ch <= "z") begin
                ch = ch - 8'h20;
            end
            if (ch != cmd_word[8 * (cmd_len - 1 - i) +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // Advance the predicted state by one received byte and return its result word.
    function automatic line_result_t decode_byte(logic [7:0] c);
        line_result_t r;
        r = '0;
        if (c == CHAR_CR || c == CHAR_LF) begin
            if (line_len == 0) begin
                r.ev = EV_EMPTY;
            end else if (line_is({16'h0, WORD_READ}, 4)) begin
                r.ev = EV_READ;
            end else if (line_is(WORD_STREAM, 6)) begin
                r.ev = EV_STREAM_ON;
                stream_on = 1'b1;
            end else if (line_is({16'h0, WORD_STOP}, 4)) begin
                r.ev = EV_STREAM_OFF;
                stream_on = 1'b0;
            end else if (line_is({16'h0, WORD_HELP}, 4)) begin
                r.ev = EV_HELP;
            end else begin
                r.ev = EV_UNKNOWN;
            end
            line_len = 0;
        end else if (c == CHAR_BS || c == CHAR_DEL) begin
            if (line_len > 0) begin
                line_len--;
            end
        end else if (line_len < BUFFER_BYTES - 1) begin
            line_chars[line_len] = c;
            line_len++;
        end else begin
            r.dropped = 1'b1;
        end
        r.stream = stream_on;
        return r;
    endfunction

    // Any byte that is stored as a character.
    function automatic logic [7:0] any_plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CHAR_CR || b == CHAR_LF || b == CHAR_BS || b == CHAR_DEL);
        return b;
    endfunction

    function automatic logic [7:0] erase_byte();
        return ($urandom_range(0, 1) == 1) ? CHAR_BS : CHAR_DEL;
    endfunction

    function automatic logic [7:0] end_byte();
        return ($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF;
    endfunction

    // Offer one byte, after an optional idle burst, and wait until it is taken.
    task automatic offer_byte(input logic [7:0] b, input logic fixed, input line_result_t want,
                              input int gap_pct);
        int n;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        row_fixed  <= fixed;
        row_expect <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Check every result word against the oldest expectation, then log accepted bytes.
    always @(posedge aclk) begin : scoreboard
        line_result_t want;
        line_result_t predicted;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("result word 0x%02h arrived with nothing expected",
                                           m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    event_seen[want.ev]++;
                    if (want.dropped) begin
                        dropped_seen++;
                    end
                    if (m_tdata[2:0] !== want.ev || m_tdata[3] !== want.stream ||
                        m_tdata[4] !== want.dropped || m_tdata[7:5] !== 3'b000) begin
                        note_failure($sformatf(
                            "result %0d: event %0d/%0d stream %b/%b dropped %b/%b pad %b %s",
                            results_seen, want.ev, m_tdata[2:0], want.stream, m_tdata[3],
                            want.dropped, m_tdata[4], m_tdata[7:5], "(expected/actual)"));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = decode_byte(s_tdata);
                pending_results.push_back(row_fixed ? row_expect : predicted);
                bytes_taken++;
            end
        end
    end

    // End the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off, always ready near the end.
    initial begin : result_sink
        int n;
        forever begin
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (quiet_tail) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Input side: reset, directed table, random command lines, drain.
    initial begin : byte_source
        int         i;
        int         j;
        int         n;
        int         kind;
        int         cmd_len;
        int         miss_at;
        int         gap_pct;
        logic [47:0] cmd_word;
        logic [7:0] c;

        // Build the random byte stream from whole lines.
        while (rx_plan.size() < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // Command word in random case; from 45 up one character is spoiled or one is added.
                case ($urandom_range(0, 3))
                    0: begin cmd_word = {16'h0, WORD_READ}; cmd_len = 4; end
                    1: begin cmd_word = WORD_STREAM; cmd_len = 6; end
                    2: begin cmd_word = {16'h0, WORD_STOP}; cmd_len = 4; end
                    default: begin cmd_word = {16'h0, WORD_HELP}; cmd_len = 4; end
                endcase
                miss_at = (kind >= 45) ? $urandom_range(0, cmd_len) : -1;
                if ($urandom_range(0, 6) == 0) begin
                    rx_plan.push_back(erase_byte());
                end
                for (j = 0; j < cmd_len; j++) begin
                    c = cmd_word[8 * (cmd_len - 1 - j) +: 8];
                    if ($urandom_range(0, 1) == 1) begin
                        c = c | 8'h20;
                    end
                    if (j == miss_at) begin
                        case ($urandom_range(0, 3))
                            0: c = c + 8'h01;
                            1: c = c ^ 8'h80;
                            2: c = fold_edges[$urandom_range(0, 3)];
                            default: c = 8'h00;
                        endcase
                    end
                    // A typo that is erased again leaves the word intact.
                    if ($urandom_range(0, 5) == 0) begin
                        rx_plan.push_back(any_plain_byte());
                        rx_plan.push_back(erase_byte());
                    end
                    rx_plan.push_back(c);
                end
                if (miss_at == cmd_len) begin
                    rx_plan.push_back(any_plain_byte());
                end
                rx_plan.push_back(end_byte());
            end else if (kind < 70) begin
                // Line that runs up to and past the store limit.
                n = $urandom_range(BUFFER_BYTES - 3, BUFFER_BYTES + 6);
                repeat (n) rx_plan.push_back(any_plain_byte());
                if ($urandom_range(0, 1) == 1) begin
                    rx_plan.push_back(erase_byte());
                    rx_plan.push_back(any_plain_byte());
                end
                rx_plan.push_back(end_byte());
            end else if (kind < 80) begin
                // Erases on an empty line, then an empty line end.
                n = $urandom_range(0, 3);
                repeat (n) rx_plan.push_back(erase_byte());
                rx_plan.push_back(end_byte());
            end else begin
                // Raw noise over the whole byte range.
                n = $urandom_range(1, 12);
                repeat (n) rx_plan.push_back(8'($urandom_range(0, 255)));
                rx_plan.push_back(end_byte());
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        for (i = 0; i < $size(directed_rows); i++) begin
            offer_byte(directed_rows[i].rx, directed_rows[i].fixed, directed_rows[i].res, 20);
        end

        // Random lines, with changing idle density and one full pause.
        gap_pct = 0;
        for (i = 0; i < rx_plan.size(); i++) begin
            if (i % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 45;
                endcase
            end
            if (i >= rx_plan.size() - QUIET_ITEMS) begin
                quiet_tail = 1'b1;
                gap_pct = 0;
            end
            if (i == HOLD_AT) begin
                hold_request = 1'b1;
            end
            if (i == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
            offer_byte(rx_plan[i], 1'b0, PREDICTED, gap_pct);
        end
        s_tvalid <= 1'b0;

        // Let every expected word arrive, then watch for strays.
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Fed %0d bytes (%0d from the table), checked %0d result words, %0d dropped.",
                 bytes_taken, $size(directed_rows), results_seen, dropped_seen);
        $display("Line ends seen: empty %0d, read %0d, stream on %0d, stream off %0d, %s %0d, %s %0d.",
                 event_seen[EV_EMPTY], event_seen[EV_READ], event_seen[EV_STREAM_ON],
                 event_seen[EV_STREAM_OFF], "help", event_seen[EV_HELP],
                 "unknown", event_seen[EV_UNKNOWN]);
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d expected result words never arrived",
                                   pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
